/* rtl/round_robin_interval_task_scheduler_top_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_INTERVAL_TASK_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_INTERVAL_TASK_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property that holds at every edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/rrts_pkg.sv */
// Types and constants of the round-robin interval task scheduler.
`default_nettype none
package rrts_pkg;
	localparam int TASK_SLOTS = 8;
	localparam int TIME_BITS  = 32;
	localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
	localparam int PTR_BITS   = $clog2(TASK_SLOTS + 1);
	localparam int OP_BITS    = 3;
	localparam int REQ_BITS   = 3;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [PTR_BITS-1:0]  ptr_t;
	typedef logic [TIME_BITS-1:0] time_t;

	// Null link and header visit position share the same code.
	localparam ptr_t NULL_PTR = ptr_t'(TASK_SLOTS);

	typedef enum logic [OP_BITS-1:0] {
		OP_POLL         = 3'd0,
		OP_SET_INTERVAL = 3'd1,
		OP_START        = 3'd2,
		OP_STOP         = 3'd3,
		OP_DESTROY      = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_UNLINK,
		ST_VISIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic unlink;
		logic visit;
	} ctl_cmd_t;

	typedef struct packed {
		logic poll_go;
	} dp_stat_t;
endpackage
`default_nettype wire

/* rtl/round_robin_interval_task_scheduler_top.sv */
// Top level of the round-robin interval task scheduler.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  command   | start / busy         | opcode, task_req, operand_value
//  result    | done (1-cycle pulse) | fired, fired_task, tasks_in_rotation, rejected
//
// A transaction is taken at an edge with start high and busy low.
// Set interval, start, stop, destroy and a poll of an empty rotation pass through
// the exec and response states; a poll of a non-empty rotation goes through exec
// (hop lookup), unlink (of a destroyed successor), visit (due compare and add)
// and response.
// One transaction is in flight at a time; busy stays high until done has pulsed.
// arst_n clears the task table, links, head, visit position and count at once.
// The receiver cannot stall; done lasts one cycle, results until the next exec.
`default_nettype none
module round_robin_interval_task_scheduler_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire [rrts_pkg::OP_BITS-1:0]       opcode,
	input  wire [rrts_pkg::REQ_BITS-1:0]      task_req,
	input  wire [rrts_pkg::TIME_BITS-1:0]     operand_value,
	output logic                              done,
	output logic                              fired,
	output logic [rrts_pkg::SLOT_BITS-1:0]    fired_task,
	output logic [rrts_pkg::PTR_BITS-1:0]     tasks_in_rotation,
	output logic                              rejected
);
	rrts_pkg::ctl_cmd_t cmd;
	rrts_pkg::dp_stat_t stat;

	// Controller: exec, unlink and visit (non-empty polls only), then response.
	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: task table, rotation links and the result registers.
	rrts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.opcode            (opcode),
		.task_req          (task_req),
		.operand_value     (operand_value),
		.stat              (stat),
		.fired             (fired),
		.fired_task        (fired_task),
		.tasks_in_rotation (tasks_in_rotation),
		.rejected          (rejected)
	);
endmodule
`default_nettype wire

/* rtl/rrts_ctrl.sv */
// Sequencing state machine of the scheduler.
`default_nettype none
`include "round_robin_interval_task_scheduler_top_defines.svh"
module rrts_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  rrts_pkg::dp_stat_t  stat,
	output rrts_pkg::ctl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	rrts_pkg::state_t state_q, state_d;
	logic [3:0] cmd_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrts_pkg::ST_IDLE: begin
				if (start) state_d = rrts_pkg::ST_EXEC;
			end
			rrts_pkg::ST_EXEC: begin
				state_d = stat.poll_go ? rrts_pkg::ST_UNLINK : rrts_pkg::ST_RESP;
			end
			rrts_pkg::ST_UNLINK: state_d = rrts_pkg::ST_VISIT;
			rrts_pkg::ST_VISIT:  state_d = rrts_pkg::ST_RESP;
			rrts_pkg::ST_RESP:   state_d = rrts_pkg::ST_IDLE;
			default:             state_d = rrts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			rrts_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			rrts_pkg::ST_EXEC:   cmd.exec = 1'b1;
			rrts_pkg::ST_UNLINK: cmd.unlink = 1'b1;
			rrts_pkg::ST_VISIT:  cmd.visit = 1'b1;
			rrts_pkg::ST_RESP:   done = 1'b1;
			default:             busy = 1'b1;
		endcase
	end

	assign cmd_vec = {cmd.latch, cmd.exec, cmd.unlink, cmd.visit};

	`RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`RRTS_ASSERT_NEXT(a_done_frees, done, !busy && !done, "block not free after result")
	`RRTS_ASSERT(a_cmd_onehot, $onehot0(cmd_vec), "more than one datapath command")
endmodule
`default_nettype wire

/* rtl/rrts_dp.sv */
// Task table, rotation links and poll/command datapath.
`default_nettype none
`include "round_robin_interval_task_scheduler_top_defines.svh"
module rrts_dp (
	input  wire                               clk,
	input  wire                               arst_n,
	input  rrts_pkg::ctl_cmd_t                cmd,
	input  wire [rrts_pkg::OP_BITS-1:0]       opcode,
	input  wire [rrts_pkg::REQ_BITS-1:0]      task_req,
	input  wire [rrts_pkg::TIME_BITS-1:0]     operand_value,
	output rrts_pkg::dp_stat_t                stat,
	output logic                              fired,
	output logic [rrts_pkg::SLOT_BITS-1:0]    fired_task,
	output logic [rrts_pkg::PTR_BITS-1:0]     tasks_in_rotation,
	output logic                              rejected
);
	logic [rrts_pkg::OP_BITS-1:0]  op_q;
	logic [rrts_pkg::REQ_BITS-1:0] req_q;
	rrts_pkg::time_t               val_q;

	rrts_pkg::time_t interval_q [rrts_pkg::TASK_SLOTS];
	rrts_pkg::time_t due_q      [rrts_pkg::TASK_SLOTS];
	rrts_pkg::ptr_t  link_q     [rrts_pkg::TASK_SLOTS];
	logic [rrts_pkg::TASK_SLOTS-1:0] alive_q, started_q, destroyed_q;
	rrts_pkg::ptr_t  head_q, vp_q, count_q, nxt_q;
	logic            fired_q, rej_q;
	rrts_pkg::slot_t ftask_q;

	rrts_pkg::slot_t vp_slot, nxt_slot, req_slot;
	rrts_pkg::ptr_t  succ_vp, nxt_link;
	logic            req_ok, nxt_ok, due_hit;
	rrts_pkg::time_t due_next;

	assign vp_slot  = vp_q[rrts_pkg::SLOT_BITS-1:0];
	assign nxt_slot = nxt_q[rrts_pkg::SLOT_BITS-1:0];
	assign req_slot = rrts_pkg::SLOT_BITS'(req_q);
	assign req_ok   = rrts_pkg::PTR_BITS'(req_q) < rrts_pkg::NULL_PTR;
	assign nxt_ok   = nxt_q < rrts_pkg::NULL_PTR;

	// Successor of the visit position: header points at the list head.
	assign succ_vp  = (vp_q >= rrts_pkg::NULL_PTR) ? head_q : link_q[vp_slot];
	assign nxt_link = link_q[nxt_slot];
	assign due_hit  = alive_q[nxt_slot] && (val_q >= due_q[nxt_slot]);
	assign due_next = val_q + interval_q[nxt_slot];

	assign stat.poll_go = (op_q == rrts_pkg::OP_POLL) && (count_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= opcode;
			req_q <= task_req;
			val_q <= operand_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrts_pkg::TASK_SLOTS; i++) begin
				interval_q[i] <= '0;
				due_q[i]      <= '0;
				link_q[i]     <= rrts_pkg::NULL_PTR;
			end
			alive_q     <= '0;
			started_q   <= '0;
			destroyed_q <= '0;
			head_q      <= rrts_pkg::NULL_PTR;
			vp_q        <= rrts_pkg::NULL_PTR;
			count_q     <= '0;
			nxt_q       <= rrts_pkg::NULL_PTR;
			fired_q     <= 1'b0;
			ftask_q     <= '0;
			rej_q       <= 1'b0;
		end else begin
			if (cmd.exec) begin
				fired_q <= 1'b0;
				ftask_q <= '0;
				rej_q   <= 1'b0;
				if (stat.poll_go) begin
					nxt_q <= succ_vp;
				end else if (req_ok) begin
					case (op_q)
						rrts_pkg::OP_SET_INTERVAL: interval_q[req_slot] <= val_q;
						rrts_pkg::OP_START: begin
							if (destroyed_q[req_slot]) begin
								rej_q <= 1'b1;
							end else begin
								alive_q[req_slot] <= 1'b1;
								if (!started_q[req_slot]) begin
									link_q[req_slot]    <= head_q;
									head_q              <= rrts_pkg::PTR_BITS'(req_slot);
									count_q             <= count_q + 1'b1;
									started_q[req_slot] <= 1'b1;
								end
							end
						end
						rrts_pkg::OP_STOP: alive_q[req_slot] <= 1'b0;
						rrts_pkg::OP_DESTROY: begin
							alive_q[req_slot]     <= 1'b0;
							destroyed_q[req_slot] <= 1'b1;
						end
						default: rej_q <= 1'b0;
					endcase
				end
			end

			// Drop a destroyed successor before the hop.
			if (cmd.unlink && nxt_ok && destroyed_q[nxt_slot]) begin
				if (vp_q >= rrts_pkg::NULL_PTR) begin
					head_q <= nxt_link;
				end else begin
					link_q[vp_slot] <= nxt_link;
				end
				link_q[nxt_slot] <= rrts_pkg::NULL_PTR;
				count_q          <= count_q - 1'b1;
				nxt_q            <= nxt_link;
			end

			if (cmd.visit) begin
				if (!nxt_ok) begin
					vp_q <= rrts_pkg::NULL_PTR;
				end else begin
					vp_q <= nxt_q;
					if (due_hit) begin
						due_q[nxt_slot] <= due_next;
						fired_q         <= 1'b1;
						ftask_q         <= nxt_slot;
					end
				end
			end
		end
	end

	assign fired             = fired_q;
	assign fired_task        = ftask_q;
	assign tasks_in_rotation = count_q;
	assign rejected          = rej_q;

	`RRTS_ASSERT(a_count_range, count_q <= rrts_pkg::NULL_PTR, "rotation count above slot count")
	`RRTS_ASSERT(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "rotation count jumped")
	`RRTS_ASSERT(a_fire_excl, !(fired_q && rej_q), "fired and rejected in one transaction")
endmodule
`default_nettype wire

/* tb/round_robin_interval_task_scheduler_top_test.sv */
// Self-checking testbench for the round-robin interval task scheduler top level.
module round_robin_interval_task_scheduler_top_test;
	import rrts_pkg::*;

	// Opcodes past OP_DESTROY have no function; the block must ignore them.
	localparam logic [OP_BITS-1:0] OP_RSVD_FIRST = OP_DESTROY + 1;
	localparam logic [OP_BITS-1:0] OP_RSVD_LAST  = '1;
	localparam time_t              TIME_MAX      = '1;
	// Sender gap rates (percent of cycles) for the three traffic phases.
	localparam int IDLE_LIGHT = 7;
	localparam int IDLE_HEAVY = 78;
	localparam int IDLE_NONE  = 0;
	// Cycles to watch for stray done pulses after the last result.
	localparam int DRAIN_CYCLES = 20;

	// One queued command transaction plus how the driver should present it.
	typedef struct packed {
		logic [OP_BITS-1:0]  op;
		logic [REQ_BITS-1:0] req;
		time_t               value;
		logic [6:0]          idle_pct;  // chance of a gap cycle before this one
		logic                drain;     // hold off until all results are back
	} sched_cmd_t;

	// One result transaction as the scheduler should report it.
	typedef struct packed {
		logic  fired;
		slot_t fired_task;
		ptr_t  in_rotation;
		logic  rejected;
	} sched_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OP_BITS-1:0]  opcode = '0;
	logic [REQ_BITS-1:0] task_req = '0;
	time_t               operand_value = '0;
	logic                busy;
	logic                done;
	logic                fired;
	slot_t               fired_task;
	ptr_t                tasks_in_rotation;
	logic                rejected;

	round_robin_interval_task_scheduler_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.opcode            (opcode),
		.task_req          (task_req),
		.operand_value     (operand_value),
		.done              (done),
		.fired             (fired),
		.fired_task        (fired_task),
		.tasks_in_rotation (tasks_in_rotation),
		.rejected          (rejected)
	);

	always #5 clk = ~clk;

	// Shadow copy of the task table and rotation.
	time_t period   [TASK_SLOTS];
	time_t due_at   [TASK_SLOTS];
	logic  alive    [TASK_SLOTS];
	logic  started  [TASK_SLOTS];
	logic  gone     [TASK_SLOTS];
	ptr_t  succ     [TASK_SLOTS];
	ptr_t  head_ptr;
	ptr_t  visit_pos;
	ptr_t  rot_count;

	sched_cmd_t    cmd_q[$];        // commands not yet offered
	sched_result_t expected_q[$];   // results owed by accepted transactions
	sched_cmd_t    next_cmd;
	logic          took = 1'b0;     // a transaction was accepted at the last edge
	int            accepted_cnt = 0;
	int            total_cmds = 0;
	int            fail_cnt = 0;
	time_t         now_ms = '0;     // running poll time for the random traffic

	// Successor of a visit position; the header's successor is the list head.
	function automatic ptr_t next_of(input ptr_t pos);
		return (pos == NULL_PTR) ? head_ptr : succ[pos[SLOT_BITS-1:0]];
	endfunction

	// Applies one command to the shadow state and returns the result it owes.
	function automatic sched_result_t predict_schedule(input logic [OP_BITS-1:0] op,
			input logic [REQ_BITS-1:0] req, input time_t now);
		sched_result_t r;
		ptr_t          nxt;
		slot_t         s;
		r = '0;
		case (op)
			OP_POLL: begin
				if (rot_count != 0) begin
					// A destroyed successor is unlinked before the hop.
					nxt = next_of(visit_pos);
					if (nxt != NULL_PTR && gone[nxt[SLOT_BITS-1:0]]) begin
						s = nxt[SLOT_BITS-1:0];
						if (visit_pos == NULL_PTR)
							head_ptr = succ[s];
						else
							succ[visit_pos[SLOT_BITS-1:0]] = succ[s];
						succ[s] = NULL_PTR;
						rot_count--;
					end
					nxt = next_of(visit_pos);
					visit_pos = nxt;
					if (nxt != NULL_PTR) begin
						s = nxt[SLOT_BITS-1:0];
						// Plain unsigned compare, due time wraps mod 2^32.
						if (alive[s] && now >= due_at[s]) begin
							due_at[s] = now + period[s];
							r.fired = 1'b1;
							r.fired_task = s;
						end
					end
				end
			end
			OP_SET_INTERVAL: period[req] = now;
			OP_START: begin
				if (gone[req]) begin
					r.rejected = 1'b1;
				end else begin
					alive[req] = 1'b1;
					// First start links the slot in at the head.
					if (!started[req]) begin
						succ[req] = head_ptr;
						head_ptr = ptr_t'(req);
						rot_count++;
						started[req] = 1'b1;
					end
				end
			end
			OP_STOP: alive[req] = 1'b0;
			OP_DESTROY: begin
				alive[req] = 1'b0;
				gone[req] = 1'b1;
			end
			default: ;
		endcase
		r.in_rotation = rot_count;
		return r;
	endfunction

	task automatic push_cmd(input logic [OP_BITS-1:0] op, input int req, input time_t value,
			input int idle_pct, input bit drain);
		sched_cmd_t c;
		c.op = op;
		c.req = req[REQ_BITS-1:0];
		c.value = value;
		c.idle_pct = idle_pct[6:0];
		c.drain = drain;
		cmd_q.push_back(c);
		total_cmds++;
	endtask

	// Random traffic: mostly polls on an advancing clock, with task setup in
	// between; destroy is kept rare since a destroyed slot never comes back.
	task automatic add_random(input int count, input int idle_pct);
		int    roll;
		int    sel;
		time_t value;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 999);
			sel = $urandom_range(0, 19);
			if (roll < 3) begin
				push_cmd(OP_DESTROY, $urandom_range(0, TASK_SLOTS - 1), $urandom(),
					idle_pct, i == 0);
			end else if (roll < 600) begin
				if (sel == 0)
					now_ms = $urandom();
				else if (sel == 1)
					now_ms = TIME_MAX - $urandom_range(0, 40);  // just short of wrap
				else
					now_ms = now_ms + $urandom_range(0, 25);
				push_cmd(OP_POLL, $urandom_range(0, TASK_SLOTS - 1), now_ms, idle_pct,
					i == 0 || $urandom_range(0, 99) == 0);
			end else begin
				if (roll < 720)
					value = (sel == 0) ? time_t'($urandom()) :
						(sel == 1) ? TIME_MAX : time_t'($urandom_range(0, 80));
				else
					value = $urandom();
				push_cmd((roll < 720) ? OP_SET_INTERVAL :
					(roll < 850) ? OP_START :
					(roll < 960) ? OP_STOP :
					OP_BITS'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
					$urandom_range(0, TASK_SLOTS - 1), value, idle_pct, i == 0);
			end
		end
	endtask

	// Driver: at the falling edge, once the offered transaction has gone
	// (or none is offered), either idle a cycle or present the next one.
	// A drain-marked command waits until every owed result has arrived.
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (cmd_q.size() != 0 && !(cmd_q[0].drain && expected_q.size() != 0) &&
					$urandom_range(0, 99) >= cmd_q[0].idle_pct) begin
				next_cmd = cmd_q.pop_front();
				start <= 1'b1;
				opcode <= next_cmd.op;
				task_req <= next_cmd.req;
				operand_value <= next_cmd.value;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: results are checked first, since a done pulse always belongs
	// to an earlier transaction than one accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			if (done === 1'b1) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none outstanding, expected none actual %b/%0d/%0d/%b",
						$time, fired, fired_task, tasks_in_rotation, rejected);
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					check_field("fired", want.fired, fired);
					check_field("fired_task", want.fired_task, fired_task);
					check_field("tasks_in_rotation", want.in_rotation, tasks_in_rotation);
					check_field("rejected", want.rejected, rejected);
				end
			end
			if (start && !busy) begin
				expected_q.push_back(predict_schedule(opcode, task_req, operand_value));
				accepted_cnt++;
			end
			took <= start && !busy;
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			period[i] = '0;
			due_at[i] = '0;
			alive[i] = 1'b0;
			started[i] = 1'b0;
			gone[i] = 1'b0;
			succ[i] = NULL_PTR;
		end
		head_ptr = NULL_PTR;
		visit_pos = NULL_PTR;
		rot_count = '0;

		// Directed opening: field extremes, every opcode and the corner cases.
		push_cmd(OP_POLL, 0, '0, IDLE_LIGHT, 0);              // empty rotation
		push_cmd(OP_SET_INTERVAL, 0, TIME_MAX, IDLE_LIGHT, 0);
		push_cmd(OP_SET_INTERVAL, TASK_SLOTS - 1, '0, IDLE_LIGHT, 0);
		push_cmd(OP_SET_INTERVAL, 3, 5, IDLE_LIGHT, 0);
		push_cmd(OP_START, 0, '0, IDLE_LIGHT, 0);
		push_cmd(OP_START, TASK_SLOTS - 1, TIME_MAX, IDLE_LIGHT, 0);
		push_cmd(OP_START, 3, '0, IDLE_LIGHT, 0);
		push_cmd(OP_START, TASK_SLOTS - 1, '0, IDLE_LIGHT, 0); // already linked
		push_cmd(OP_POLL, 0, TIME_MAX, IDLE_LIGHT, 0);         // due time wraps
		push_cmd(OP_POLL, 0, TIME_MAX, IDLE_LIGHT, 0);
		push_cmd(OP_POLL, 0, TIME_MAX, IDLE_LIGHT, 0);
		push_cmd(OP_POLL, 0, '0, IDLE_LIGHT, 0);               // header visit
		push_cmd(OP_STOP, TASK_SLOTS - 1, '0, IDLE_LIGHT, 0);
		push_cmd(OP_DESTROY, 5, '0, IDLE_LIGHT, 0);            // never started
		push_cmd(OP_START, 5, '0, IDLE_LIGHT, 1);              // rejected
		push_cmd(OP_POLL, 0, 10, IDLE_LIGHT, 0);
		push_cmd(OP_DESTROY, 3, '0, IDLE_LIGHT, 0);            // slot now being visited
		push_cmd(OP_POLL, 0, 10, IDLE_LIGHT, 0);
		push_cmd(OP_POLL, 0, 10, IDLE_LIGHT, 0);
		push_cmd(OP_POLL, 0, 10, IDLE_LIGHT, 0);
		push_cmd(OP_POLL, 0, 10, IDLE_LIGHT, 0);               // unlinks it
		push_cmd(OP_RSVD_FIRST, TASK_SLOTS - 1, TIME_MAX, IDLE_LIGHT, 0);
		push_cmd(OP_RSVD_LAST, 0, '0, IDLE_LIGHT, 0);
		push_cmd(OP_START, TASK_SLOTS - 1, '0, IDLE_LIGHT, 0); // restart after stop
		now_ms = 10;

		add_random(610, IDLE_LIGHT);
		add_random(610, IDLE_HEAVY);
		add_random(610, IDLE_NONE);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < total_cmds || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* round_robin_interval_task_scheduler_top.f */
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_interval_task_scheduler_top.sv
tb/round_robin_interval_task_scheduler_top_test.sv
